[src/complex_integer_alu_macros.svh]
// Assertion macros used by the RTL top level.
`ifndef COMPLEX_INTEGER_ALU_MACROS_SVH
`define COMPLEX_INTEGER_ALU_MACROS_SVH
`ifndef SYNTHESIS
`define CIA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CIA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CIA_ASSERT_SAME(label, clk, rst, ante, cons)
`define CIA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[src/cia_pkg.sv]
`default_nettype none
package cia_pkg;
   typedef enum logic [1:0] {
      KIND_ADD,
      KIND_SUB,
      KIND_MUL,
      KIND_DIV
   } kind_type;

   localparam int RES_W = 33;

   typedef struct packed {
      logic valid;
      logic is_div;
      logic dz;
      logic neg_re;
      logic neg_im;
   } ctl_type;
endpackage
`default_nettype wire

[src/cia_front.sv]
`default_nettype none
module cia_front import cia_pkg::*; #(
   parameter int W = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire logic                in_valid,
   input  wire kind_type            in_kind,
   input  wire logic signed [W-1:0] in_a,
   input  wire logic signed [W-1:0] in_b,
   input  wire logic signed [W-1:0] in_c,
   input  wire logic signed [W-1:0] in_d,
   output ctl_type                  ctl_out,
   output logic [2*W-1:0]           den_out,
   output logic [2*W-1:0]           mag_re_out,
   output logic [2*W-1:0]           mag_im_out,
   output logic [RES_W-1:0]         pass_re_out,
   output logic [RES_W-1:0]         pass_im_out
);
   localparam int PW = 2 * W;
   localparam int XW = 2 * W + RES_W + 1;

   logic                s1_valid_ff;
   kind_type            s1_kind_ff;
   logic signed [W-1:0] s1_a_ff, s1_b_ff, s1_c_ff, s1_d_ff;

   logic                 s2_valid_ff;
   kind_type             s2_kind_ff;
   logic                 s2_dz_ff, s2_dz_in;
   logic signed [PW-1:0] s2_ac_ff, s2_bd_ff, s2_ad_ff, s2_bc_ff;
   logic [PW-1:0]        s2_cc_ff, s2_dd_ff;
   logic [RES_W-1:0]     s2_pass_re_ff, s2_pass_im_ff, s2_pass_re_in, s2_pass_im_in;

   logic                 s3_valid_ff;
   kind_type             s3_kind_ff;
   logic                 s3_dz_ff;
   logic signed [PW:0]   s3_nre_ff, s3_nim_ff, s3_nre_in, s3_nim_in;
   logic [PW-1:0]        s3_den_ff, s3_den_in;
   logic [RES_W-1:0]     s3_pass_re_ff, s3_pass_im_ff, s3_pass_re_in, s3_pass_im_in;

   ctl_type              ctl_ff, ctl_in;
   logic [PW-1:0]        den_ff, mag_re_ff, mag_im_ff, mag_re_in, mag_im_in;
   logic [RES_W-1:0]     pass_re_ff, pass_im_ff;

   always_comb begin
      logic signed [W:0]    sre, sim;
      logic signed [XW-1:0] xre, xim;
      if (s1_kind_ff == KIND_SUB) begin
         sre = (W+1)'(s1_a_ff) - (W+1)'(s1_c_ff);
         sim = (W+1)'(s1_b_ff) - (W+1)'(s1_d_ff);
      end else begin
         sre = (W+1)'(s1_a_ff) + (W+1)'(s1_c_ff);
         sim = (W+1)'(s1_b_ff) + (W+1)'(s1_d_ff);
      end
      xre = XW'(sre);
      xim = XW'(sim);
      s2_pass_re_in = xre[RES_W-1:0];
      s2_pass_im_in = xim[RES_W-1:0];
      s2_dz_in = (s1_kind_ff == KIND_DIV) && (s1_c_ff == '0) && (s1_d_ff == '0);
   end

   always_comb begin
      logic signed [PW:0]   mre, mim;
      logic signed [XW-1:0] xre, xim;
      s3_nre_in = (PW+1)'(s2_ac_ff) + (PW+1)'(s2_bd_ff);
      s3_nim_in = (PW+1)'(s2_bc_ff) - (PW+1)'(s2_ad_ff);
      s3_den_in = s2_cc_ff + s2_dd_ff;
      mre = (PW+1)'(s2_ac_ff) - (PW+1)'(s2_bd_ff);
      mim = (PW+1)'(s2_ad_ff) + (PW+1)'(s2_bc_ff);
      xre = XW'(mre);
      xim = XW'(mim);
      if (s2_kind_ff == KIND_MUL) begin
         s3_pass_re_in = xre[RES_W-1:0];
         s3_pass_im_in = xim[RES_W-1:0];
      end else begin
         s3_pass_re_in = s2_pass_re_ff;
         s3_pass_im_in = s2_pass_im_ff;
      end
   end

   always_comb begin
      logic signed [PW:0] nre, nim;
      nre = -s3_nre_ff;
      nim = -s3_nim_ff;
      mag_re_in = s3_nre_ff[PW] ? nre[PW-1:0] : s3_nre_ff[PW-1:0];
      mag_im_in = s3_nim_ff[PW] ? nim[PW-1:0] : s3_nim_ff[PW-1:0];
      ctl_in.valid  = s3_valid_ff;
      ctl_in.is_div = (s3_kind_ff == KIND_DIV);
      ctl_in.dz     = s3_dz_ff;
      ctl_in.neg_re = s3_nre_ff[PW];
      ctl_in.neg_im = s3_nim_ff[PW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         ctl_ff      <= '0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         ctl_ff      <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_kind_ff    <= in_kind;
         s1_a_ff       <= in_a;
         s1_b_ff       <= in_b;
         s1_c_ff       <= in_c;
         s1_d_ff       <= in_d;
         s2_kind_ff    <= s1_kind_ff;
         s2_dz_ff      <= s2_dz_in;
         s2_ac_ff      <= s1_a_ff * s1_c_ff;
         s2_bd_ff      <= s1_b_ff * s1_d_ff;
         s2_ad_ff      <= s1_a_ff * s1_d_ff;
         s2_bc_ff      <= s1_b_ff * s1_c_ff;
         s2_cc_ff      <= PW'(s1_c_ff * s1_c_ff);
         s2_dd_ff      <= PW'(s1_d_ff * s1_d_ff);
         s2_pass_re_ff <= s2_pass_re_in;
         s2_pass_im_ff <= s2_pass_im_in;
         s3_kind_ff    <= s2_kind_ff;
         s3_dz_ff      <= s2_dz_ff;
         s3_nre_ff     <= s3_nre_in;
         s3_nim_ff     <= s3_nim_in;
         s3_den_ff     <= s3_den_in;
         s3_pass_re_ff <= s3_pass_re_in;
         s3_pass_im_ff <= s3_pass_im_in;
         den_ff        <= s3_den_ff;
         mag_re_ff     <= mag_re_in;
         mag_im_ff     <= mag_im_in;
         pass_re_ff    <= s3_pass_re_ff;
         pass_im_ff    <= s3_pass_im_ff;
      end
   end

   assign ctl_out     = ctl_ff;
   assign den_out     = den_ff;
   assign mag_re_out  = mag_re_ff;
   assign mag_im_out  = mag_im_ff;
   assign pass_re_out = pass_re_ff;
   assign pass_im_out = pass_im_ff;
endmodule
`default_nettype wire

[src/cia_div_cell.sv]
`default_nettype none
module cia_div_cell import cia_pkg::*; #(
   parameter int W = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire ctl_type          ctl_in,
   input  wire logic [2*W-1:0]   den_in,
   input  wire logic [2*W-1:0]   rem_re_in,
   input  wire logic [2*W-1:0]   q_re_in,
   input  wire logic [2*W-1:0]   rem_im_in,
   input  wire logic [2*W-1:0]   q_im_in,
   input  wire logic [RES_W-1:0] pass_re_in,
   input  wire logic [RES_W-1:0] pass_im_in,
   output ctl_type               ctl_out,
   output logic [2*W-1:0]        den_out,
   output logic [2*W-1:0]        rem_re_out,
   output logic [2*W-1:0]        q_re_out,
   output logic [2*W-1:0]        rem_im_out,
   output logic [2*W-1:0]        q_im_out,
   output logic [RES_W-1:0]      pass_re_out,
   output logic [RES_W-1:0]      pass_im_out
);
   localparam int NB = 2 * W;

   ctl_type          ctl_ff;
   logic [NB-1:0]    den_ff, rem_re_ff, q_re_ff, rem_im_ff, q_im_ff;
   logic [NB-1:0]    rem_re_in2, q_re_in2, rem_im_in2, q_im_in2;
   logic [RES_W-1:0] pass_re_ff, pass_im_ff;

   always_comb begin
      logic [NB:0] hre, him, dre, dim;
      logic        ge_re, ge_im;
      hre   = {rem_re_in, q_re_in[NB-1]};
      him   = {rem_im_in, q_im_in[NB-1]};
      dre   = hre - {1'b0, den_in};
      dim   = him - {1'b0, den_in};
      ge_re = (hre >= {1'b0, den_in});
      ge_im = (him >= {1'b0, den_in});
      rem_re_in2 = ge_re ? dre[NB-1:0] : hre[NB-1:0];
      rem_im_in2 = ge_im ? dim[NB-1:0] : him[NB-1:0];
      q_re_in2   = {q_re_in[NB-2:0], ge_re};
      q_im_in2   = {q_im_in[NB-2:0], ge_im};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff     <= den_in;
         rem_re_ff  <= rem_re_in2;
         q_re_ff    <= q_re_in2;
         rem_im_ff  <= rem_im_in2;
         q_im_ff    <= q_im_in2;
         pass_re_ff <= pass_re_in;
         pass_im_ff <= pass_im_in;
      end
   end

   assign ctl_out     = ctl_ff;
   assign den_out     = den_ff;
   assign rem_re_out  = rem_re_ff;
   assign q_re_out    = q_re_ff;
   assign rem_im_out  = rem_im_ff;
   assign q_im_out    = q_im_ff;
   assign pass_re_out = pass_re_ff;
   assign pass_im_out = pass_im_ff;
endmodule
`default_nettype wire

[src/complex_integer_alu.sv]
// Complex integer ALU: add, subtract, multiply or divide two Gaussian integers with
// OPERAND_WIDTH-bit signed parts, giving 33-bit parts; a quotient truncates toward zero
// and a zero divisor returns zero parts with rsp_divide_by_zero set. Fully pipelined:
// one item per cycle while not stalled, through four front stages for products and
// sums, then one divider cell per quotient bit, then the output register.
// A stall on the result side freezes the whole pipeline.
`default_nettype none
`include "complex_integer_alu_macros.svh"
module complex_integer_alu import cia_pkg::*; #(
   parameter int OPERAND_WIDTH = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [1:0]                      req_kind,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_first_re,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_first_im,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_second_re,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_second_im,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [RES_W-1:0]              rsp_result_re,
   output logic signed [RES_W-1:0]              rsp_result_im,
   output logic                                 rsp_divide_by_zero
);
   localparam int W  = OPERAND_WIDTH;
   localparam int NB = 2 * W;
   localparam int XW = NB + RES_W + 1;

   logic adv;

   ctl_type          ctl_w     [0:NB];
   logic [NB-1:0]    den_w     [0:NB];
   logic [NB-1:0]    rem_re_w  [0:NB];
   logic [NB-1:0]    q_re_w    [0:NB];
   logic [NB-1:0]    rem_im_w  [0:NB];
   logic [NB-1:0]    q_im_w    [0:NB];
   logic [RES_W-1:0] pass_re_w [0:NB];
   logic [RES_W-1:0] pass_im_w [0:NB];

   logic             rsp_valid_ff;
   logic [RES_W-1:0] re_ff, im_ff, re_in, im_in;
   logic             dz_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   cia_front #(.W(W)) u_front (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_valid),
      .in_kind     (kind_type'(req_kind)),
      .in_a        (req_first_re),
      .in_b        (req_first_im),
      .in_c        (req_second_re),
      .in_d        (req_second_im),
      .ctl_out     (ctl_w[0]),
      .den_out     (den_w[0]),
      .mag_re_out  (q_re_w[0]),
      .mag_im_out  (q_im_w[0]),
      .pass_re_out (pass_re_w[0]),
      .pass_im_out (pass_im_w[0])
   );

   assign rem_re_w[0] = '0;
   assign rem_im_w[0] = '0;

   for (genvar i = 0; i < NB; i++) begin : g_cell
      cia_div_cell #(.W(W)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .adv         (adv),
         .ctl_in      (ctl_w[i]),
         .den_in      (den_w[i]),
         .rem_re_in   (rem_re_w[i]),
         .q_re_in     (q_re_w[i]),
         .rem_im_in   (rem_im_w[i]),
         .q_im_in     (q_im_w[i]),
         .pass_re_in  (pass_re_w[i]),
         .pass_im_in  (pass_im_w[i]),
         .ctl_out     (ctl_w[i+1]),
         .den_out     (den_w[i+1]),
         .rem_re_out  (rem_re_w[i+1]),
         .q_re_out    (q_re_w[i+1]),
         .rem_im_out  (rem_im_w[i+1]),
         .q_im_out    (q_im_w[i+1]),
         .pass_re_out (pass_re_w[i+1]),
         .pass_im_out (pass_im_w[i+1])
      );
   end

   always_comb begin
      logic [XW-1:0] qre, qim, nre, nim;
      qre = XW'(q_re_w[NB]);
      qim = XW'(q_im_w[NB]);
      nre = ctl_w[NB].neg_re ? -qre : qre;
      nim = ctl_w[NB].neg_im ? -qim : qim;
      if (ctl_w[NB].dz) begin
         re_in = '0;
         im_in = '0;
      end else if (ctl_w[NB].is_div) begin
         re_in = nre[RES_W-1:0];
         im_in = nim[RES_W-1:0];
      end else begin
         re_in = pass_re_w[NB];
         im_in = pass_im_w[NB];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= ctl_w[NB].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         re_ff <= re_in;
         im_ff <= im_in;
         dz_ff <= ctl_w[NB].dz;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_re      = re_ff;
   assign rsp_result_im      = im_ff;
   assign rsp_divide_by_zero = dz_ff;

   `CIA_ASSERT_SAME(a_dz_zero, clock, reset, rsp_valid && rsp_divide_by_zero, rsp_result_re == '0 && rsp_result_im == '0)
   `CIA_ASSERT_NEXT(a_freeze, clock, reset, !adv, $stable(ctl_w[NB]) && $stable(ctl_w[0]))
   `CIA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_result_re))
endmodule
`default_nettype wire

[test/complex_integer_alu_test.sv]
`timescale 1ns / 1ps
`default_nettype none
module complex_integer_alu_test;
   import cia_pkg::*;

   localparam int OW = 16;
   localparam int LATENCY = 2 * OW + 5;
   localparam int STUCK_LIMIT = 20000;

   typedef struct packed {
      logic signed [RES_W-1:0] re;
      logic signed [RES_W-1:0] im;
      logic                    dz;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_kind = '0;
   logic signed [OW-1:0] req_first_re = '0;
   logic signed [OW-1:0] req_first_im = '0;
   logic signed [OW-1:0] req_second_re = '0;
   logic signed [OW-1:0] req_second_im = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [RES_W-1:0] rsp_result_re;
   logic signed [RES_W-1:0] rsp_result_im;
   logic rsp_divide_by_zero;

   answer_type answers[$];
   int errors = 0;
   int sent = 0;
   int received = 0;
   int idle_pct = 30;
   int hold_cycles = 0;
   int stuck = 0;
   int kind_seen[4] = '{0, 0, 0, 0};

   complex_integer_alu #(.OPERAND_WIDTH(OW)) dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic signed [63:0] quot(logic signed [63:0] n, logic signed [63:0] d);
      logic [63:0] mag;
      logic [63:0] q;
      mag = n < 0 ? -n : n;
      q = mag / d;
      return n < 0 ? -q : q;
   endfunction

   function automatic answer_type gaussian_answer(kind_type k, logic signed [OW-1:0] a,
         logic signed [OW-1:0] b, logic signed [OW-1:0] c, logic signed [OW-1:0] d);
      answer_type r;
      logic signed [63:0] x, y, z, w, den, nre, nim;
      x = a;
      y = b;
      z = c;
      w = d;
      r = '0;
      case (k)
         KIND_ADD: begin
            r.re = RES_W'(x + z);
            r.im = RES_W'(y + w);
         end
         KIND_SUB: begin
            r.re = RES_W'(x - z);
            r.im = RES_W'(y - w);
         end
         KIND_MUL: begin
            r.re = RES_W'(x * z - y * w);
            r.im = RES_W'(x * w + y * z);
         end
         default: begin
            den = z * z + w * w;
            if (den == 0) begin
               r.dz = 1'b1;
            end else begin
               nre = x * z + y * w;
               nim = y * z - x * w;
               r.re = RES_W'(quot(nre, den));
               r.im = RES_W'(quot(nim, den));
            end
         end
      endcase
      return r;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch on item %0d: %s got %0h want %0h", received, what, got, want);
   endtask

   task automatic send(kind_type k, logic [OW-1:0] a, logic [OW-1:0] b, logic [OW-1:0] c,
         logic [OW-1:0] d);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= k;
      req_first_re <= a;
      req_first_im <= b;
      req_second_re <= c;
      req_second_im <= d;
      answers.push_back(gaussian_answer(k, a, b, c, d));
      kind_seen[k]++;
      do @(posedge clock); while (req_stall);
      sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (answers.size() != 0) @(negedge clock);
   endtask

   function automatic logic [OW-1:0] pick();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return OW'(int'($urandom_range(6)) - 3);
         default: return OW'($urandom);
      endcase
   endfunction

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_pct > 0 && $urandom_range(99) < idle_pct;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers.size() == 0) begin
            report("unexpected item", 0, 0);
         end else begin
            answer_type w;
            w = answers.pop_front();
            if (rsp_result_re !== w.re) report("result_re", rsp_result_re, w.re);
            if (rsp_result_im !== w.im) report("result_im", rsp_result_im, w.im);
            if (rsp_divide_by_zero !== w.dz) report("divide_by_zero", rsp_divide_by_zero, w.dz);
         end
         received++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
            || (req_valid == 1'b0 && answers.size() == 0)) begin
         stuck <= 0;
      end else begin
         stuck <= stuck + 1;
         if (stuck >= STUCK_LIMIT) begin
            $display("watchdog: no progress");
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic test_directed();
      logic [OW-1:0] ends[4];
      ends = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
      for (int k = 0; k < 4; k++) begin
         send(kind_type'(k), ends[0], ends[0], ends[0], ends[0]);
         send(kind_type'(k), ends[1], ends[1], ends[0], ends[1]);
         send(kind_type'(k), ends[1], ends[0], ends[3], ends[2]);
      end
      send(KIND_DIV, 16'd7, 16'hfff9, 16'h0000, 16'h0000);
      send(KIND_DIV, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
      send(KIND_DIV, 16'd7, 16'd3, 16'd2, 16'd0);
      send(KIND_DIV, 16'hfff9, 16'd3, 16'd2, 16'd1);
      send(KIND_DIV, 16'd1, 16'd1, 16'h8000, 16'h8000);
      send(KIND_MUL, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
      drain();
   endtask

   task automatic test_random(int n);
      for (int i = 0; i < n; i++) begin
         send(kind_type'($urandom_range(3)), pick(), pick(), pick(), pick());
      end
   endtask

   task automatic test_zero_divisor();
      for (int i = 0; i < 40; i++) begin
         send(KIND_DIV, pick(), pick(), 16'h0000, 16'h0000);
      end
   endtask

   task automatic test_back_pressure();
      hold_cycles = 3 * LATENCY;
      idle_pct = 0;
      test_random(4 * LATENCY);
      idle_pct = 30;
   endtask

   task automatic test_no_idle();
      idle_pct = 0;
      test_random(300);
      idle_pct = 30;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_zero_divisor();
      test_random(700);
      drain();
      test_back_pressure();
      test_no_idle();
      test_random(650);
      drain();
      repeat (LATENCY + 10) @(negedge clock);
      $display("sent %0d items, checked %0d: add %0d, sub %0d, mul %0d, div %0d",
         sent, received, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
      $display("covered operand extremes, zero divisor, long output stall and full-rate bursts");
      if (errors == 0 && answers.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire

[complex_integer_alu.f]
+incdir+src
src/cia_pkg.sv
src/cia_front.sv
src/cia_div_cell.sv
src/complex_integer_alu.sv
test/complex_integer_alu_test.sv
